@@ rtl/core/pcxd_pkg.sv @@
// Shared types and constants of the PCX RLE image decoder.
// Used by the front, queue, back, top level and checker; no dependencies.
package pcxd_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned SIZE_W       = 24;
    localparam int unsigned DIM_W        = 17;
    localparam int unsigned MAX_W        = 16;
    localparam int unsigned PIX_LEFT_W   = 33;
    localparam int unsigned RUN_W        = 6;
    localparam int unsigned KIND_W       = 2;
    localparam int unsigned ERR_W        = 2;
    localparam int unsigned IN_DATA_W    = 8;
    localparam int unsigned OUT_FIELDS_W = 76;
    localparam int unsigned OUT_DATA_W   = 80;

    localparam int unsigned RUN_BASE     = 192;
    localparam int unsigned PAL_BYTES    = 256 * 3;
    localparam int unsigned HEADER_BYTES = 128;

    localparam int unsigned QUEUE_DEPTH  = 4;

    localparam logic [KIND_W-1:0] KIND_SIZE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PIXEL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PALETTE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

    localparam logic [ERR_W-1:0] ERR_FORMAT = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RUN    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SHORT  = 2'd2;

    // One command from the front: a size, a palette entry, an error, or a
    // group of identical pixels that may end in a run overflow error.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [RUN_W-1:0]  count;
        logic              err_after;
        logic [ERR_W-1:0]  err_code;
        logic [BYTE_W-1:0] pix;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

endpackage

@@ rtl/core/pcx_rle_image_decoder.sv @@
// Top level of the PCX RLE image decoder: front, command queue and back.
// Depends on pcxd_pkg, pcxd_front, pcxd_queue and pcxd_back.
//
// Feed a PCX file one byte per item, with s_tuser high on its first byte, after
// writing the file length on the cfg channel. While the command queue is not
// full, the block accepts one byte per clock for header, literal, skipped and
// palette bytes. A run byte gives nothing itself; the byte after it yields 0 to
// 63 pixel items, which leave the back part at one per clock through its output
// register while m_tready is high; the front keeps accepting bytes until the
// command queue (QUEUE_DEPTH entries, default 4) is full. Results carry
// their kind in m_tuser and tlast marks the final result caused by one byte.
// Errors stop the file until the next start byte. No clearing pass after reset.
module pcx_rle_image_decoder
#(
    parameter int unsigned QUEUE_DEPTH = pcxd_pkg::QUEUE_DEPTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pcxd_pkg::SIZE_W-1:0]         cfg_data,      // file_size
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pcxd_pkg::IN_DATA_W-1:0]      s_tdata,       // data_byte
    input  logic [0:0]                          s_tuser,       // file_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_value, image_width, image_height, palette_index, red, green,
    // blue, error_code, zero fill
    output logic [pcxd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [pcxd_pkg::KIND_W-1:0]         m_tuser,       // result_kind
    output logic                                m_tlast
);

    pcxd_pkg::cmd_slot_t push;
    pcxd_pkg::cmd_slot_t head;
    logic                full;
    logic                pop;

    assign s_tready = !full;

    pcxd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_accept (s_tvalid && s_tready),
        .in_byte   (s_tdata),
        .in_start  (s_tuser[0]),
        .push      (push)
    );

    pcxd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (full),
        .head  (head)
    );

    pcxd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/core/pcxd_front.sv @@
// Front part: parses header, RLE pixel data and palette bytes into commands.
// Depends on pcxd_pkg; holds the file_size configuration register.
module pcxd_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pcxd_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                           in_accept,
    input  logic [pcxd_pkg::BYTE_W-1:0]    in_byte,
    input  logic                           in_start,
    output pcxd_pkg::cmd_slot_t            push
);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_PIXELS  = 3'd1;
    localparam logic [2:0] PH_SKIP    = 3'd2;
    localparam logic [2:0] PH_PALETTE = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    localparam int unsigned SW = pcxd_pkg::SIZE_W;
    localparam int unsigned PW = pcxd_pkg::PIX_LEFT_W;

    localparam logic [SW-1:0] POS_ENCODING = SW'(2);
    localparam logic [SW-1:0] POS_BPP      = SW'(3);
    localparam logic [SW-1:0] POS_XMAX_LO  = SW'(8);
    localparam logic [SW-1:0] POS_XMAX_HI  = SW'(9);
    localparam logic [SW-1:0] POS_YMAX_LO  = SW'(10);
    localparam logic [SW-1:0] POS_YMAX_HI  = SW'(11);
    localparam logic [SW-1:0] POS_PLANES   = SW'(65);
    localparam logic [SW-1:0] POS_HDR_END  = SW'(pcxd_pkg::HEADER_BYTES - 1);
    localparam logic [SW-1:0] MIN_FILE     = SW'(pcxd_pkg::HEADER_BYTES + pcxd_pkg::PAL_BYTES);
    localparam logic [SW-1:0] PAL_LEN      = SW'(pcxd_pkg::PAL_BYTES);
    localparam logic [7:0]    ENC_RLE      = 8'd1;
    localparam logic [7:0]    BPP_EIGHT    = 8'd8;
    localparam logic [7:0]    PLANES_ONE   = 8'd1;
    localparam logic [7:0]    RUN_MARK     = 8'(pcxd_pkg::RUN_BASE);
    localparam logic [7:0]    LAST_ENTRY   = 8'd255;

    logic [SW-1:0]                   file_size_reg;
    logic [2:0]                      phase_reg, phase_next;
    logic [SW-1:0]                   byte_pos_reg, byte_pos_next;
    logic [pcxd_pkg::MAX_W-1:0]      wmax_reg, wmax_next;
    logic [pcxd_pkg::MAX_W-1:0]      hmax_reg, hmax_next;
    logic                            format_ok_reg, format_ok_next;
    logic [PW-1:0]                   pix_left_reg, pix_left_next;
    logic [pcxd_pkg::RUN_W-1:0]      run_len_reg, run_len_next;
    logic                            run_pend_reg, run_pend_next;
    logic [15:0]                     colour_reg, colour_next;
    logic [1:0]                      cbyte_reg, cbyte_next;
    logic [7:0]                      entry_reg, entry_next;
    logic                            failed_reg, failed_next;

    logic [SW-1:0]                   pos;
    logic [SW-1:0]                   pal_start;
    logic [pcxd_pkg::DIM_W-1:0]      img_w, img_h;
    logic [2*pcxd_pkg::DIM_W-1:0]    img_area;
    logic [pcxd_pkg::RUN_W-1:0]      take;
    logic                            overflow;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg <= '0;
            phase_reg     <= PH_HEADER;
            byte_pos_reg  <= '0;
            wmax_reg      <= '0;
            hmax_reg      <= '0;
            format_ok_reg <= 1'b1;
            pix_left_reg  <= '0;
            run_len_reg   <= '0;
            run_pend_reg  <= 1'b0;
            colour_reg    <= '0;
            cbyte_reg     <= '0;
            entry_reg     <= '0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                file_size_reg <= cfg_data;
            end
            phase_reg     <= phase_next;
            byte_pos_reg  <= byte_pos_next;
            wmax_reg      <= wmax_next;
            hmax_reg      <= hmax_next;
            format_ok_reg <= format_ok_next;
            pix_left_reg  <= pix_left_next;
            run_len_reg   <= run_len_next;
            run_pend_reg  <= run_pend_next;
            colour_reg    <= colour_next;
            cbyte_reg     <= cbyte_next;
            entry_reg     <= entry_next;
            failed_reg    <= failed_next;
        end
    end

    assign pal_start = (file_size_reg >= PAL_LEN) ? file_size_reg - PAL_LEN : '0;
    assign img_w     = {1'b0, wmax_reg} + pcxd_pkg::DIM_W'(1);
    assign img_h     = {1'b0, hmax_reg} + pcxd_pkg::DIM_W'(1);
    assign img_area  = img_w * img_h;

    always_comb
    begin
        phase_next     = phase_reg;
        byte_pos_next  = byte_pos_reg;
        wmax_next      = wmax_reg;
        hmax_next      = hmax_reg;
        format_ok_next = format_ok_reg;
        pix_left_next  = pix_left_reg;
        run_len_next   = run_len_reg;
        run_pend_next  = run_pend_reg;
        colour_next    = colour_reg;
        cbyte_next     = cbyte_reg;
        entry_next     = entry_reg;
        failed_next    = failed_reg;
        push           = '0;
        pos            = '0;
        take           = '0;
        overflow       = 1'b0;

        if (in_accept)
        begin
            if (in_start)
            begin
                phase_next     = PH_HEADER;
                byte_pos_next  = '0;
                wmax_next      = '0;
                hmax_next      = '0;
                format_ok_next = 1'b1;
                pix_left_next  = '0;
                run_len_next   = '0;
                run_pend_next  = 1'b0;
                colour_next    = '0;
                cbyte_next     = '0;
                entry_next     = '0;
                failed_next    = 1'b0;
            end

            if (!failed_next && phase_next != PH_DONE)
            begin
                pos = byte_pos_next;
                if (pos != '1)
                begin
                    byte_pos_next = pos + SW'(1);
                end

                unique case (phase_next)
                    PH_HEADER:
                    begin
                        if (pos == POS_ENCODING && in_byte != ENC_RLE)
                            format_ok_next = 1'b0;
                        if (pos == POS_BPP && in_byte != BPP_EIGHT)
                            format_ok_next = 1'b0;
                        if (pos == POS_PLANES && in_byte != PLANES_ONE)
                            format_ok_next = 1'b0;
                        if (pos == POS_XMAX_LO) wmax_next[7:0]  = in_byte;
                        if (pos == POS_XMAX_HI) wmax_next[15:8] = in_byte;
                        if (pos == POS_YMAX_LO) hmax_next[7:0]  = in_byte;
                        if (pos == POS_YMAX_HI) hmax_next[15:8] = in_byte;
                        if (pos == POS_HDR_END)
                        begin
                            push.valid = 1'b1;
                            if (!format_ok_next || file_size_reg < MIN_FILE)
                            begin
                                push.cmd.kind     = pcxd_pkg::KIND_ERROR;
                                push.cmd.err_code = format_ok_next ? pcxd_pkg::ERR_SHORT
                                                                   : pcxd_pkg::ERR_FORMAT;
                                failed_next       = 1'b1;
                                phase_next        = PH_DONE;
                            end
                            else
                            begin
                                push.cmd.kind   = pcxd_pkg::KIND_SIZE;
                                push.cmd.width  = img_w;
                                push.cmd.height = img_h;
                                pix_left_next   = img_area[PW-1:0];
                                phase_next      = PH_PIXELS;
                            end
                        end
                    end

                    PH_PIXELS:
                    begin
                        if (pos >= pal_start)
                        begin
                            push.valid        = 1'b1;
                            push.cmd.kind     = pcxd_pkg::KIND_ERROR;
                            push.cmd.err_code = pcxd_pkg::ERR_SHORT;
                            failed_next       = 1'b1;
                            phase_next        = PH_DONE;
                        end
                        else if (run_pend_next)
                        begin
                            // clip the run to what still fits in the image
                            take = (PW'(run_len_next) > pix_left_next)
                                 ? pix_left_next[pcxd_pkg::RUN_W-1:0] : run_len_next;
                            overflow          = run_len_next != take;
                            pix_left_next     = pix_left_next - PW'(take);
                            run_pend_next     = 1'b0;
                            run_len_next      = '0;
                            push.valid        = (take != '0) || overflow;
                            push.cmd.kind     = pcxd_pkg::KIND_PIXEL;
                            push.cmd.count    = take;
                            push.cmd.err_after = overflow;
                            push.cmd.err_code = pcxd_pkg::ERR_RUN;
                            push.cmd.pix      = in_byte;
                            if (overflow)
                            begin
                                failed_next = 1'b1;
                                phase_next  = PH_DONE;
                            end
                            else if (pix_left_next == '0)
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                        else if (in_byte >= RUN_MARK)
                        begin
                            run_len_next  = pcxd_pkg::RUN_W'(in_byte - RUN_MARK);
                            run_pend_next = 1'b1;
                        end
                        else
                        begin
                            push.valid     = 1'b1;
                            push.cmd.kind  = pcxd_pkg::KIND_PIXEL;
                            push.cmd.count = pcxd_pkg::RUN_W'(1);
                            push.cmd.pix   = in_byte;
                            pix_left_next  = pix_left_next - PW'(1);
                            if (pix_left_next == '0)
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end

                    PH_SKIP, PH_PALETTE:
                    begin
                        if (phase_next == PH_PALETTE || pos >= pal_start)
                        begin
                            phase_next = PH_PALETTE;
                            unique case (cbyte_next)
                                2'd0:
                                begin
                                    colour_next[7:0] = in_byte;
                                    cbyte_next       = 2'd1;
                                end
                                2'd1:
                                begin
                                    colour_next[15:8] = in_byte;
                                    cbyte_next        = 2'd2;
                                end
                                default:
                                begin
                                    push.valid     = 1'b1;
                                    push.cmd.kind  = pcxd_pkg::KIND_PALETTE;
                                    push.cmd.idx   = entry_next;
                                    push.cmd.red   = colour_next[7:0];
                                    push.cmd.green = colour_next[15:8];
                                    push.cmd.blue  = in_byte;
                                    cbyte_next     = 2'd0;
                                    if (entry_next == LAST_ENTRY)
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                    entry_next = entry_next + 8'd1;
                                end
                            endcase
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

@@ rtl/core/pcxd_queue.sv @@
// Short command queue between the parsing front and the expanding back.
// Depends on pcxd_pkg for the command type.
module pcxd_queue
#(
    parameter int unsigned DEPTH = pcxd_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pcxd_pkg::cmd_slot_t push,
    input  logic                pop,
    output logic                full,
    output pcxd_pkg::cmd_slot_t head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pcxd_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head.valid = count_reg != '0;
    assign head.cmd   = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

@@ rtl/core/pcxd_back.sv @@
// Back part: expands queued commands into result items, one per cycle when
// not stalled, through a registered output stage. Depends on pcxd_pkg.
module pcxd_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcxd_pkg::cmd_slot_t                 head,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pcxd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [pcxd_pkg::KIND_W-1:0]         m_tuser,
    output logic                                m_tlast
);

    pcxd_pkg::cmd_t                  act_reg, act_next;
    logic                            act_valid_reg, act_valid_next;
    logic                            out_valid_reg, out_valid_next;
    logic [pcxd_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [pcxd_pkg::KIND_W-1:0]     out_kind_reg, out_kind_next;
    logic                            out_last_reg, out_last_next;

    logic                            out_free;
    logic                            emit;
    logic                            done;
    logic [pcxd_pkg::KIND_W-1:0]     emit_kind;
    logic [pcxd_pkg::BYTE_W-1:0]     emit_pix;
    logic [pcxd_pkg::ERR_W-1:0]      emit_err;

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = act_valid_reg && out_free;
    assign pop      = head.valid && (!act_valid_reg || (emit && done));

    always_comb
    begin
        emit_kind     = act_reg.kind;
        done          = 1'b1;
        out_last_next = 1'b1;
        act_next      = act_reg;
        if (act_reg.kind == pcxd_pkg::KIND_PIXEL)
        begin
            if (act_reg.count != '0)
            begin
                done           = (act_reg.count == pcxd_pkg::RUN_W'(1)) && !act_reg.err_after;
                out_last_next  = done;
                act_next.count = act_reg.count - pcxd_pkg::RUN_W'(1);
            end
            else
            begin
                // run ran past the image: trailing error after its pixels
                emit_kind = pcxd_pkg::KIND_ERROR;
            end
        end
        emit_pix = (emit_kind == pcxd_pkg::KIND_PIXEL) ? act_reg.pix : '0;
        emit_err = (emit_kind == pcxd_pkg::KIND_ERROR) ? act_reg.err_code : '0;

        if (pop)
            act_next = head.cmd;
        else if (!emit)
            act_next = act_reg;

        act_valid_next = pop ? 1'b1 : (emit && done) ? 1'b0 : act_valid_reg;

        out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_kind_next  = emit ? emit_kind : out_kind_reg;
        out_data_next  = emit
                       ? pcxd_pkg::OUT_DATA_W'({emit_err, act_reg.blue, act_reg.green,
                                                act_reg.red, act_reg.idx, act_reg.height,
                                                act_reg.width, emit_pix})
                       : out_data_reg;
        if (!emit)
            out_last_next = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_valid_reg <= act_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/core/pcxd_checker.sv @@
// Port-level checks of the PCX RLE image decoder, bound to the top level.
// Depends on pcxd_pkg and pcx_rle_image_decoder.
module pcxd_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pcxd_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [pcxd_pkg::KIND_W-1:0]     m_tuser,
    input logic                            m_tlast
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == pcxd_pkg::KIND_PIXEL |-> m_tdata[pcxd_pkg::OUT_DATA_W-1:8] == '0)
        else $error("pixel result carries stray fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == pcxd_pkg::KIND_ERROR || m_tuser == pcxd_pkg::KIND_SIZE
                     || m_tuser == pcxd_pkg::KIND_PALETTE) |-> m_tlast)
        else $error("single result of a byte without tlast");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == pcxd_pkg::KIND_ERROR
        |-> m_tdata[73:0] == '0 && m_tdata[75:74] != 2'd3)
        else $error("malformed error result");

endmodule

bind pcx_rle_image_decoder pcxd_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
